FILE: rtl/core/htirf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package htirf_pkg;
  localparam int NUM_BUCKETS = 128;
  localparam int WAYS = 4;
  localparam int BKT_W = $clog2(NUM_BUCKETS) > 0 ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W = $clog2(WAYS) > 0 ? $clog2(WAYS) : 1;
  // row: WAYS x {key, value}, then one valid bit per way on top
  localparam int VLD_LSB = WAYS * 64;
  localparam int ROW_W = WAYS * 64 + WAYS;
  localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(NUM_BUCKETS - 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_value;
  } rsp_t;

  typedef struct packed {
    logic clear;  // write an empty row at the clear pointer
    logic load;   // capture request, start bucket read
    logic exec;   // compare ways, write back, form result
    logic pop;    // result taken by receiver
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic rsp_valid;
  } sts_t;

  // bucket index: modulo by a power of two is a mask
  function automatic logic [BKT_W-1:0] bucket_of(input logic [31:0] k);
    logic [31:0] r;
    r = k % 32'(NUM_BUCKETS);
    return r[BKT_W-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/htirf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module htirf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/htirf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module htirf_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire htirf_pkg::cmd_t  cmd,
  input  wire htirf_pkg::req_t  req,
  output htirf_pkg::sts_t       sts,
  output htirf_pkg::rsp_t       rsp
);
  localparam int W = htirf_pkg::WAYS;

  htirf_pkg::req_t r;
  logic [htirf_pkg::BKT_W-1:0] bkt, clr_addr, ram_waddr;
  logic [htirf_pkg::ROW_W-1:0] row, row_wr, ram_wdata;
  logic [W-1:0] vrow, vrow_next;
  logic [W-1:0] hit, free;
  logic any_hit, any_free, wr_en, ram_we;
  logic [htirf_pkg::WAY_W-1:0] hit_w, free_w;
  logic [31:0] hit_val;
  htirf_pkg::rsp_t rsp_next;
  logic rsp_v;

  assign bkt = htirf_pkg::bucket_of(r.key);

  // clearing pass owns the write port after reset
  assign ram_we    = cmd.clear || wr_en;
  assign ram_waddr = cmd.clear ? clr_addr : bkt;
  assign ram_wdata = cmd.clear ? '0 : row_wr;

  htirf_ram #(.WIDTH(htirf_pkg::ROW_W), .DEPTH(htirf_pkg::NUM_BUCKETS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(cmd.load), .raddr(htirf_pkg::bucket_of(req.key)), .rdata(row)
  );

  always_comb begin
    vrow = row[htirf_pkg::VLD_LSB +: W];
    for (int i = 0; i < W; i++) begin
      hit[i]  = vrow[i] && (row[i*64+32 +: 32] == r.key);
      free[i] = !vrow[i];
    end
    any_hit = 1'b0; any_free = 1'b0;
    hit_w = '0; free_w = '0; hit_val = '0;
    for (int i = W-1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1; hit_w = htirf_pkg::WAY_W'(i); hit_val = row[i*64 +: 32];
      end
      if (free[i]) begin
        any_free = 1'b1; free_w = htirf_pkg::WAY_W'(i);
      end
    end
    row_wr = row;
    vrow_next = vrow;
    wr_en = 1'b0;
    rsp_next.status = htirf_pkg::ST_NOT_FOUND;
    rsp_next.found_value = '0;
    case (r.req_type)
      htirf_pkg::OP_INSERT: begin
        if (any_hit) begin
          row_wr[hit_w*64 +: 32] = r.value;
          wr_en = cmd.exec;
          rsp_next.status = htirf_pkg::ST_UPDATED;
        end else if (any_free) begin
          row_wr[free_w*64 +: 64] = {r.key, r.value};
          vrow_next[free_w] = 1'b1;
          wr_en = cmd.exec;
          rsp_next.status = htirf_pkg::ST_INSERTED;
        end else begin
          rsp_next.status = htirf_pkg::ST_FULL;
        end
      end
      htirf_pkg::OP_REMOVE: begin
        if (any_hit) begin
          vrow_next[hit_w] = 1'b0;
          wr_en = cmd.exec;
          rsp_next.status = htirf_pkg::ST_REMOVED;
        end
      end
      htirf_pkg::OP_FIND: begin
        if (any_hit) begin
          rsp_next.status = htirf_pkg::ST_FOUND;
          rsp_next.found_value = hit_val;
        end
      end
      default: ;
    endcase
    row_wr[htirf_pkg::VLD_LSB +: W] = vrow_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r <= req;
    end
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
    if (rst) begin
      rsp_v <= 1'b0;
      clr_addr <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.exec) begin
        rsp_v <= 1'b1;
      end else if (cmd.pop) begin
        rsp_v <= 1'b0;
      end
    end
  end

  assign sts.rsp_valid  = rsp_v;
  assign sts.clear_last = (clr_addr == htirf_pkg::BKT_LAST);
endmodule
`default_nettype wire

FILE: rtl/core/htirf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module htirf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            out_ready,
  output logic                 out_valid,
  input  wire htirf_pkg::sts_t sts,
  output htirf_pkg::cmd_t      cmd
);
  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;
  state_t state;
  logic pop;

  assign out_valid = sts.rsp_valid;
  assign pop = out_valid && out_ready;
  // accept while result register is free or being emptied this cycle
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign cmd.clear = (state == S_CLEAR);
  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = (state == S_EXEC);
  assign cmd.pop  = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: if (sts.clear_last) state <= S_IDLE;
        S_IDLE: if (cmd.load) state <= S_EXEC;
        S_EXEC: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/hash_table_insert_remove_find.sv
// Hash table, insert / remove / find on 32-bit keys, WAYS slots per bucket.
// Input channel (in_valid/in_ready/in_data): one request item with req_type,
// key and value. Output channel (out_valid/out_ready/out_data): one result
// item per request with status and found_value.
// Bucket = key mod NUM_BUCKETS. A bucket row (all ways' keys, values and
// per-way valid bits) is one word of a block RAM.
// Steps: the accepted item and its bucket row are registered on acceptance
// (S_IDLE); in S_EXEC the ways are compared, the row is written back and
// the result is registered. No new item is accepted while one is in
// S_EXEC: the read-then-write loop holds the single bucket RAM port pair.
// The result register lets a new item be accepted in the cycle its
// predecessor's result is taken; if the receiver stalls, out_valid holds and
// no new item is accepted until the result is gone.
// Reset (rst, synchronous): after rst drops, a clearing pass writes an empty
// row to every bucket (NUM_BUCKETS, 128 rows); in_ready stays low until it
// is done.
`timescale 1ns / 1ps
`default_nettype none
module hash_table_insert_remove_find (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire htirf_pkg::req_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output htirf_pkg::rsp_t      out_data
);
  htirf_pkg::cmd_t cmd;
  htirf_pkg::sts_t sts;

  htirf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_ready(out_ready), .out_valid(out_valid), .sts(sts), .cmd(cmd)
  );

  htirf_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(in_data), .sts(sts), .rsp(out_data)
  );
endmodule
`default_nettype wire
